FILE: rtl/rtwa_pkg.sv
// ----------------------------------------------------------------------------
// rtwa_pkg
// shared types and codes for the route table with aging
// ----------------------------------------------------------------------------
package rtwa_pkg;

	localparam int DEST_W = 16;
	localparam int HOP_W  = 16;
	localparam int CNT_W  = 7;

	typedef enum logic [2:0] {
		ACT_ADD     = 3'd0,
		ACT_LOOKUP  = 3'd1,
		ACT_REFRESH = 3'd2,
		ACT_DECAY   = 3'd3,
		ACT_REMOVE  = 3'd4,
		ACT_FLUSH   = 3'd5,
		ACT_TICK    = 3'd6,
		ACT_GET     = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_EXEC,
		CMD_COMPACT,
		CMD_INSERT
	} cmd_op_t;

	typedef struct packed {
		logic [DEST_W-1:0] dest;
		logic [HOP_W-1:0]  hop;
		logic [7:0]        cost;
		logic [7:0]        seqno;
		logic [7:0]        age;
		logic [7:0]        decay;
		logic [7:0]        last;
	} entry_t;

	typedef struct packed {
		cmd_op_t           op;
		act_t              action;
		logic [DEST_W-1:0] dest;
		logic [2:0]        pos;
		logic [7:0]        lifetime;
		logic [7:0]        threshold;
	} cmd_t;

endpackage

FILE: rtl/rtwa_cell.sv
// ----------------------------------------------------------------------------
// rtwa_cell
// one table slot: holds an entry, updates it and shifts with its neighbours
// ----------------------------------------------------------------------------
module rtwa_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rtwa_pkg::cmd_t   cmd,
	input  logic             left_v,
	input  rtwa_pkg::entry_t left_d,
	input  logic             right_v,
	input  rtwa_pkg::entry_t right_d,
	output logic             own_v,
	output rtwa_pkg::entry_t own_d,
	input  logic             hole_in,
	output logic             hole_out,
	input  logic [rtwa_pkg::CNT_W-1:0] cnt_in,
	output logic [rtwa_pkg::CNT_W-1:0] cnt_out,
	input  rtwa_pkg::entry_t rep_in,
	output rtwa_pkg::entry_t rep_out,
	input  logic             hit_in,
	output logic             hit_out,
	input  logic             kill_in,
	output logic             kill_out
);
	import rtwa_pkg::*;

	logic   v_q, nv, hit, sel, pos_hit;
	entry_t d_q, nd;
	logic [7:0] age_inc, dec_inc;

	assign pos_hit = (IDX < 8) && (32'(cmd.pos) == IDX);
	assign hit     = v_q && (d_q.dest == cmd.dest);
	assign sel     = (cmd.action == ACT_GET) ? (v_q && pos_hit) : hit;
	assign age_inc = (d_q.age == 8'hff) ? d_q.age : d_q.age + 8'd1;
	assign dec_inc = (d_q.decay == 8'hff) ? d_q.decay : d_q.decay + 8'd1;
	assign hole_out = hole_in | ~v_q;

	always_comb begin
		nv = v_q;
		nd = d_q;
		unique case (cmd.op)
			CMD_EXEC: begin
				unique case (cmd.action)
					ACT_ADD, ACT_REMOVE: begin
						if (hit) nv = 1'b0;
					end
					ACT_REFRESH: begin
						if (hit) begin
							nd.age   = 8'd0;
							nd.decay = 8'd0;
						end
					end
					ACT_DECAY: begin
						if (hit && d_q.age != d_q.last) begin
							nd.last  = d_q.age;
							nd.decay = dec_inc;
							if (dec_inc >= cmd.threshold) nv = 1'b0;
						end
					end
					ACT_FLUSH: nv = 1'b0;
					ACT_TICK: begin
						if (v_q) begin
							nd.age = age_inc;
							if (age_inc >= cmd.lifetime) nv = 1'b0;
						end
					end
					default: ;
				endcase
			end
			CMD_COMPACT: begin
				if (hole_out) begin
					nv = right_v;
					nd = right_d;
				end
			end
			CMD_INSERT: begin
				nv = left_v;
				nd = left_d;
			end
			default: ;
		endcase
	end

	assign rep_out  = rep_in | (sel ? nd : '0);
	assign hit_out  = hit_in | sel;
	assign kill_out = kill_in | (sel & v_q & ~nv);
	assign cnt_out  = cnt_in + CNT_W'(v_q);
	assign own_v    = v_q;
	assign own_d    = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else         v_q <= nv;
	end

	always_ff @(posedge clk) begin
		d_q <= nd;
	end

endmodule

FILE: rtl/route_table_with_aging_core.sv
// ----------------------------------------------------------------------------
// route_table_with_aging_core
// newest-first route table built as a chain of slot cells with entry aging
// ----------------------------------------------------------------------------
// a request runs exec, a compaction sweep of the chain, an insert step for add only
//   and a finish step; no new request is taken until the result is registered
// reset: table empty, lifetime 60, decay threshold 8, no result pending
module route_table_with_aging_core #(
	parameter int ENTRIES   = 8,
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [15:0] dest_addr,
	input  logic [15:0] next_hop_addr,
	input  logic [7:0]  path_cost,
	input  logic [7:0]  sequence_number,
	input  logic [2:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [15:0] route_dest,
	output logic [15:0] route_next_hop,
	output logic [7:0]  route_cost,
	output logic [7:0]  route_seqno,
	output logic [7:0]  route_age,
	output logic [7:0]  decay_count,
	output logic [3:0]  entry_count,
	output logic        was_removed,
	output logic        add_failed,
	output logic [3:0]  expired_count
);
	import rtwa_pkg::*;

	localparam int CYC_W = $clog2(ENTRIES + 1);
	localparam logic [DEST_W-1:0] ADDR_MASK =
		(ADDR_BITS >= DEST_W) ? {DEST_W{1'b1}} : DEST_W'((64'd1 << ADDR_BITS) - 64'd1);

	localparam logic [0:0] REG_LIFETIME  = 1'b0;
	localparam logic [0:0] REG_THRESHOLD = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_COMPACT,
		S_INSERT,
		S_FIN
	} state_t;

	state_t state_q;
	logic [CYC_W-1:0] cyc_q;

	// configuration registers
	logic [7:0] lifetime_q, threshold_q;

	// latched request
	act_t              act_q;
	logic [DEST_W-1:0] dest_q;
	logic [HOP_W-1:0]  hop_q;
	logic [7:0]        cost_q, seq_q;
	logic [2:0]        pos_q;

	// what the exec step saw
	entry_t           rep_q;
	logic             hit_q, kill_q, fail_q;
	logic [CNT_W-1:0] cnt_before_q;

	// chain wiring, element i feeds cell i
	logic             hole_c [ENTRIES+1];
	logic [CNT_W-1:0] cnt_c  [ENTRIES+1];
	entry_t           rep_c  [ENTRIES+1];
	logic             hit_c  [ENTRIES+1];
	logic             kill_c [ENTRIES+1];
	logic             cv     [ENTRIES];
	entry_t           cd     [ENTRIES];

	cmd_t   cmd;
	entry_t new_ent;
	logic   in_acc, full, fin_go;
	logic [CNT_W-1:0] cnt_now;

	// next result, loaded into the output registers when the request finishes
	logic        r_found, r_removed, r_failed;
	logic [15:0] r_dest, r_hop;
	logic [7:0]  r_cost, r_seqno, r_age, r_decay;
	logic [3:0]  r_expired;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;

	assign cnt_now = cnt_c[ENTRIES];
	assign full    = (cnt_now == CNT_W'(ENTRIES));

	// finish once the result register is free
	assign fin_go  = (state_q == S_FIN) && (!out_valid || !out_stall);

	// new route as it enters the head of the chain
	always_comb begin
		new_ent       = '0;
		new_ent.dest  = dest_q;
		new_ent.hop   = hop_q;
		new_ent.cost  = cost_q;
		new_ent.seqno = seq_q;
	end

	// command broadcast to every cell
	always_comb begin
		cmd           = '0;
		cmd.action    = act_q;
		cmd.dest      = dest_q;
		cmd.pos       = pos_q;
		cmd.lifetime  = lifetime_q;
		cmd.threshold = threshold_q;
		unique case (state_q)
			S_EXEC:    cmd.op = CMD_EXEC;
			S_COMPACT: cmd.op = CMD_COMPACT;
			S_INSERT:  cmd.op = full ? CMD_NOP : CMD_INSERT;
			default:   cmd.op = CMD_NOP;
		endcase
	end

	assign hole_c[0] = 1'b0;
	assign cnt_c[0]  = '0;
	assign rep_c[0]  = '0;
	assign hit_c[0]  = 1'b0;
	assign kill_c[0] = 1'b0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic   lv, rv;
		entry_t ld, rd;
		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign ld = new_ent;
		end else begin : g_mid
			assign lv = cv[i-1];
			assign ld = cd[i-1];
		end
		if (i == ENTRIES - 1) begin : g_tail
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_body
			assign rv = cv[i+1];
			assign rd = cd[i+1];
		end
		rtwa_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.left_v   (lv),
			.left_d   (ld),
			.right_v  (rv),
			.right_d  (rd),
			.own_v    (cv[i]),
			.own_d    (cd[i]),
			.hole_in  (hole_c[i]),
			.hole_out (hole_c[i+1]),
			.cnt_in   (cnt_c[i]),
			.cnt_out  (cnt_c[i+1]),
			.rep_in   (rep_c[i]),
			.rep_out  (rep_c[i+1]),
			.hit_in   (hit_c[i]),
			.hit_out  (hit_c[i+1]),
			.kill_in  (kill_c[i]),
			.kill_out (kill_c[i+1])
		);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q  <= 8'd60;
			threshold_q <= 8'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIFETIME:  lifetime_q  <= cfg_wdata;
				REG_THRESHOLD: threshold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// request capture and exec snapshot
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= act_t'(action);
			dest_q <= dest_addr & ADDR_MASK;
			hop_q  <= next_hop_addr & ADDR_MASK;
			cost_q <= path_cost;
			seq_q  <= sequence_number;
			pos_q  <= position;
		end
		if (state_q == S_EXEC) begin
			rep_q        <= rep_c[ENTRIES];
			hit_q        <= hit_c[ENTRIES];
			kill_q       <= kill_c[ENTRIES];
			cnt_before_q <= cnt_now;
		end
		if (state_q == S_IDLE) fail_q <= 1'b0;
		else if (state_q == S_INSERT) fail_q <= full;
	end

	// result fields per action, zero where no entry is concerned
	always_comb begin
		r_found   = 1'b0;
		r_dest    = '0;
		r_hop     = '0;
		r_cost    = '0;
		r_seqno   = '0;
		r_age     = '0;
		r_decay   = '0;
		r_removed = 1'b0;
		r_failed  = 1'b0;
		r_expired = '0;
		unique case (act_q)
			ACT_ADD: begin
				if (fail_q) begin
					r_failed = 1'b1;
				end else begin
					r_found = hit_q;
					r_dest  = 16'(dest_q);
					r_hop   = 16'(hop_q);
					r_cost  = cost_q;
					r_seqno = seq_q;
				end
			end
			ACT_LOOKUP, ACT_REFRESH, ACT_GET, ACT_DECAY, ACT_REMOVE: begin
				if (hit_q) begin
					r_found   = 1'b1;
					r_dest    = 16'(rep_q.dest);
					r_hop     = 16'(rep_q.hop);
					r_cost    = rep_q.cost;
					r_seqno   = rep_q.seqno;
					r_age     = rep_q.age;
					r_decay   = rep_q.decay;
					r_removed = kill_q;
				end
			end
			ACT_TICK: r_expired = 4'(cnt_before_q - cnt_now);
			default: ;
		endcase
	end

	// result register, held while the output is stalled
	always_ff @(posedge clk) begin
		if (fin_go) begin
			found          <= r_found;
			route_dest     <= r_dest;
			route_next_hop <= r_hop;
			route_cost     <= r_cost;
			route_seqno    <= r_seqno;
			route_age      <= r_age;
			decay_count    <= r_decay;
			was_removed    <= r_removed;
			add_failed     <= r_failed;
			expired_count  <= r_expired;
			entry_count    <= 4'(cnt_now);
		end
	end

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cyc_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fin_go) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_EXEC;
				end
				S_EXEC: begin
					cyc_q   <= '0;
					state_q <= S_COMPACT;
				end
				S_COMPACT: begin
					// one hole closes per cycle of the compaction sweep
					cyc_q <= cyc_q + CYC_W'(1);
					if (cyc_q == CYC_W'(ENTRIES - 1))
						state_q <= (act_q == ACT_ADD) ? S_INSERT : S_FIN;
				end
				S_INSERT: state_q <= S_FIN;
				S_FIN: begin
					// hold until the result register is free
					if (fin_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// route table with aging: directed and random requests checked against a
// behavioural table model, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
	import rtwa_pkg::*;

	localparam int NSLOT = 8;
	localparam logic CFG_LIFETIME  = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

	typedef struct {
		logic        found;
		logic [15:0] dest;
		logic [15:0] hop;
		logic [7:0]  cost;
		logic [7:0]  seqno;
		logic [7:0]  age;
		logic [7:0]  decay;
		logic [3:0]  count;
		logic        removed;
		logic        failed;
		logic [3:0]  expired;
	} route_rpt_t;

	logic clk, arst_n;
	logic cfg_we, cfg_index;
	logic [7:0] cfg_wdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] action, position;
	logic [15:0] dest_addr, next_hop_addr;
	logic [7:0] path_cost, sequence_number;
	logic found, was_removed, add_failed;
	logic [15:0] route_dest, route_next_hop;
	logic [7:0] route_cost, route_seqno, route_age, decay_count;
	logic [3:0] entry_count, expired_count;

	route_table_with_aging_core u_top (.*);

	// model copy of the table, newest first
	logic        m_vld [NSLOT];
	logic [15:0] m_dest [NSLOT];
	logic [15:0] m_hop [NSLOT];
	logic [7:0]  m_cost [NSLOT], m_seq [NSLOT], m_age [NSLOT];
	logic [7:0]  m_decay [NSLOT], m_last [NSLOT];
	logic [7:0]  m_lifetime, m_threshold;

	route_rpt_t pending_rpts[$];
	int errors = 0;
	int n_sent = 0, n_checked = 0;
	logic [15:0] recent_dest[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int table_fill();
		int n = 0;
		while (n < NSLOT && m_vld[n]) n++;
		return n;
	endfunction

	function automatic int match_slot(logic [15:0] d);
		for (int i = 0; i < NSLOT; i++)
			if (m_vld[i] && m_dest[i] == d) return i;
		return -1;
	endfunction

	function automatic void shift_out(int p);
		for (int i = p; i + 1 < NSLOT; i++) begin
			m_vld[i] = m_vld[i+1]; m_dest[i] = m_dest[i+1]; m_hop[i] = m_hop[i+1];
			m_cost[i] = m_cost[i+1]; m_seq[i] = m_seq[i+1]; m_age[i] = m_age[i+1];
			m_decay[i] = m_decay[i+1]; m_last[i] = m_last[i+1];
		end
		m_vld[NSLOT-1] = 1'b0;
	endfunction

	function automatic void fill_rpt(ref route_rpt_t r, input int p);
		r.found = 1; r.dest = m_dest[p]; r.hop = m_hop[p]; r.cost = m_cost[p];
		r.seqno = m_seq[p]; r.age = m_age[p]; r.decay = m_decay[p];
	endfunction

	// table update for one request, returns the expected report
	function automatic route_rpt_t route_update(act_t a, logic [15:0] d, logic [15:0] h,
			logic [7:0] c, logic [7:0] s, logic [2:0] pos);
		route_rpt_t r = '{default: '0};
		int p, i;
		p = match_slot(d);
		case (a)
			ACT_ADD: begin
				if (p >= 0) shift_out(p);
				if (table_fill() >= NSLOT) r.failed = 1;
				else begin
					for (i = NSLOT - 1; i > 0; i--) begin
						m_vld[i] = m_vld[i-1]; m_dest[i] = m_dest[i-1]; m_hop[i] = m_hop[i-1];
						m_cost[i] = m_cost[i-1]; m_seq[i] = m_seq[i-1]; m_age[i] = m_age[i-1];
						m_decay[i] = m_decay[i-1]; m_last[i] = m_last[i-1];
					end
					m_vld[0] = 1; m_dest[0] = d; m_hop[0] = h; m_cost[0] = c; m_seq[0] = s;
					m_age[0] = 0; m_decay[0] = 0; m_last[0] = 0;
					fill_rpt(r, 0);
					r.found = (p >= 0);
				end
			end
			ACT_LOOKUP: if (p >= 0) fill_rpt(r, p);
			ACT_REFRESH: if (p >= 0) begin
				m_age[p] = 0; m_decay[p] = 0; fill_rpt(r, p);
			end
			ACT_DECAY: if (p >= 0) begin
				if (m_age[p] != m_last[p]) begin
					m_last[p] = m_age[p];
					if (m_decay[p] != 8'hff) m_decay[p]++;
					fill_rpt(r, p);
					if (m_decay[p] >= m_threshold) begin
						shift_out(p); r.removed = 1;
					end
				end else fill_rpt(r, p);
			end
			ACT_REMOVE: if (p >= 0) begin
				fill_rpt(r, p); shift_out(p); r.removed = 1;
			end
			ACT_FLUSH: for (i = 0; i < NSLOT; i++) m_vld[i] = 0;
			ACT_TICK: begin
				i = 0;
				while (i < NSLOT && m_vld[i]) begin
					if (m_age[i] != 8'hff) m_age[i]++;
					if (m_age[i] >= m_lifetime) begin
						shift_out(i); r.expired++;
					end else i++;
				end
			end
			default: if (m_vld[pos]) fill_rpt(r, pos);
		endcase
		r.count = 4'(table_fill());
		return r;
	endfunction

	// one request with a random lead-in gap
	task automatic send_route_req(act_t a, logic [15:0] d, logic [15:0] h = 16'($urandom),
			logic [7:0] c = 8'($urandom), logic [7:0] s = 8'($urandom),
			logic [2:0] pos = 3'($urandom));
		@(negedge clk);
		repeat ($urandom_range(0, 3)) @(negedge clk);
		in_valid <= 1; action <= a; dest_addr <= d; next_hop_addr <= h;
		path_cost <= c; sequence_number <= s; position <= pos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_rpts.push_back(route_update(a, d, h, c, s, pos));
		if (a == ACT_ADD) begin
			recent_dest.push_back(d);
			if (recent_dest.size() > 12) void'(recent_dest.pop_front());
		end
		n_sent++;
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain_reports();
		while (pending_rpts.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_LIFETIME) m_lifetime = v; else m_threshold = v;
	endtask

	// result checker, random stall each cycle
	initial begin
		route_rpt_t e;
		out_stall = 0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 1) != 0);
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_rpts.size() == 0) begin
					$error("result with no request waiting");
					errors++;
				end else begin
					e = pending_rpts.pop_front();
					n_checked++;
					if (found !== e.found) begin
						$error("found exp %0h got %0h", e.found, found); errors++; end
					if (route_dest !== e.dest) begin
						$error("route_dest exp %0h got %0h", e.dest, route_dest); errors++; end
					if (route_next_hop !== e.hop) begin
						$error("route_next_hop exp %0h got %0h", e.hop, route_next_hop);
						errors++; end
					if (route_cost !== e.cost) begin
						$error("route_cost exp %0h got %0h", e.cost, route_cost); errors++; end
					if (route_seqno !== e.seqno) begin
						$error("route_seqno exp %0h got %0h", e.seqno, route_seqno); errors++; end
					if (route_age !== e.age) begin
						$error("route_age exp %0h got %0h", e.age, route_age); errors++; end
					if (decay_count !== e.decay) begin
						$error("decay_count exp %0h got %0h", e.decay, decay_count); errors++; end
					if (entry_count !== e.count) begin
						$error("entry_count exp %0h got %0h", e.count, entry_count); errors++; end
					if (was_removed !== e.removed) begin
						$error("was_removed exp %0h got %0h", e.removed, was_removed); errors++; end
					if (add_failed !== e.failed) begin
						$error("add_failed exp %0h got %0h", e.failed, add_failed); errors++; end
					if (expired_count !== e.expired) begin
						$error("expired_count exp %0h got %0h", e.expired, expired_count);
						errors++; end
				end
			end
		end
	end

	// extremes of every field, full table, replace, get beyond fill
	task automatic test_directed_table();
		for (int i = 0; i < 8; i++)
			send_route_req(ACT_ADD,
				(i == 0) ? 16'h0000 : (i == 7) ? 16'hffff : 16'h1000 + 16'(i),
				(i[0]) ? 16'hffff : 16'h0000, (i[0]) ? 8'hff : 8'h00, (i[0]) ? 8'h00 : 8'hff);
		send_route_req(ACT_ADD, 16'h5555);
		send_route_req(ACT_ADD, 16'h1003);
		send_route_req(ACT_GET, 16'h0000, .pos(3'd0));
		send_route_req(ACT_GET, 16'h0000, .pos(3'd7));
		send_route_req(ACT_LOOKUP, 16'hffff);
		send_route_req(ACT_LOOKUP, 16'h5555);
		send_route_req(ACT_TICK, 16'h0000);
		send_route_req(ACT_DECAY, 16'h0000);
		send_route_req(ACT_DECAY, 16'h0000);
		send_route_req(ACT_REFRESH, 16'h0000);
		send_route_req(ACT_REMOVE, 16'hffff);
		send_route_req(ACT_REMOVE, 16'hffff);
		send_route_req(ACT_GET, 16'h0000, .pos(3'd7));
		send_route_req(ACT_FLUSH, 16'h0000);
		send_route_req(ACT_GET, 16'h0000, .pos(3'd0));
		drain_reports();
	endtask

	// decay down to the threshold, including threshold extremes
	task automatic test_decay_threshold(logic [7:0] thr, int rounds);
		write_reg(CFG_THRESHOLD, thr);
		send_route_req(ACT_ADD, 16'hbeef);
		for (int i = 0; i < rounds; i++) begin
			send_route_req(ACT_TICK, 16'h0000);
			send_route_req(ACT_DECAY, 16'hbeef);
		end
		send_route_req(ACT_FLUSH, 16'h0000);
		drain_reports();
	endtask

	// age to the lifetime, several expiring in the same tick
	task automatic test_lifetime(logic [7:0] life, int ticks);
		write_reg(CFG_LIFETIME, life);
		for (int i = 0; i < 4; i++) send_route_req(ACT_ADD, 16'($urandom));
		for (int i = 0; i < ticks; i++) begin
			send_route_req(ACT_TICK, 16'h0000);
			if (i % 7 == 3) send_route_req(ACT_ADD, 16'($urandom));
		end
		send_route_req(ACT_FLUSH, 16'h0000);
		drain_reports();
	endtask

	// random traffic over a small address pool so actions hit live routes
	task automatic test_random_traffic(int n);
		act_t a;
		logic [15:0] d;
		for (int k = 0; k < n; k++) begin
			a = act_t'($urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0) a = ACT_ADD;
			if (a == ACT_FLUSH && $urandom_range(0, 3) != 0) a = ACT_TICK;
			if (recent_dest.size() != 0 && $urandom_range(0, 4) != 0)
				d = recent_dest[$urandom_range(0, recent_dest.size() - 1)];
			else d = 16'($urandom);
			send_route_req(a, d);
			// hold off once until the table has answered everything
			if (k == n / 2) drain_reports();
		end
		drain_reports();
	endtask

	initial begin
		arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0; in_valid = 0;
		action = 0; dest_addr = 0; next_hop_addr = 0; path_cost = 0;
		sequence_number = 0; position = 0;
		for (int i = 0; i < NSLOT; i++) begin
			m_vld[i] = 0; m_dest[i] = 0; m_hop[i] = 0; m_cost[i] = 0; m_seq[i] = 0;
			m_age[i] = 0; m_decay[i] = 0; m_last[i] = 0;
		end
		m_lifetime = 60; m_threshold = 8;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed_table();
		test_decay_threshold(8'd1, 3);
		test_decay_threshold(8'd255, 6);
		test_decay_threshold(8'd3, 5);
		test_lifetime(8'd1, 3);
		test_lifetime(8'd255, 20);
		test_lifetime(8'd5, 20);
		write_reg(CFG_LIFETIME, 8'd12);
		write_reg(CFG_THRESHOLD, 8'd4);
		test_random_traffic(450);
		write_reg(CFG_LIFETIME, 8'd200);
		write_reg(CFG_THRESHOLD, 8'd2);
		test_random_traffic(350);
		$display("covered %0d requests, %0d results checked, all actions,", n_sent, n_checked);
		$display("full table, decay and lifetime extremes, random stalls");
		if (errors == 0 && pending_rpts.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

FILE: route_table_with_aging_core.f
rtl/rtwa_pkg.sv
rtl/rtwa_cell.sv
rtl/route_table_with_aging_core.sv
sim/tb.sv
